// File: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
// clocked on clk and disabled in rst, both taken from the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold at every edge out of reset
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// implication: when cond holds, prop holds at the same edge
`define ASSERT_IMPLY(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("implication failed");
// implication: when cond holds, prop holds at the next edge
`define ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("next-cycle implication failed");
`endif

// File: rtl/core/tsc_pkg.sv
// constants, request codes and helpers for the two-class topological sort block
// no dependencies
`timescale 1ns / 1ps
package tsc_pkg;
  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 4096;
  localparam int NODE_W    = 11;
  localparam int NODE_AW   = $clog2(MAX_NODES);
  localparam int EDGE_AW   = $clog2(MAX_EDGES);
  localparam int EDGE_W    = $clog2(MAX_EDGES + 1);
  localparam int DEG_W     = $clog2(MAX_EDGES + 1);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);

  localparam logic [EDGE_W-1:0] EDGE_END = EDGE_W'(MAX_EDGES);

  typedef enum logic [1:0] {
    REQ_LABEL = 2'd0,
    REQ_EDGE  = 2'd1,
    REQ_RUN   = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  // node numbers start at one, memory rows at zero
  function automatic logic [NODE_AW-1:0] node_addr(input logic [NODE_W-1:0] n);
    logic [NODE_W-1:0] m;
    m = n - NODE_W'(1);
    return m[NODE_AW-1:0];
  endfunction
endpackage

// File: rtl/core/tsc_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
module tsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/two_class_topo_sort_switch_count.sv
// top level of the two-class topological sort with switch counting
// uses tsc_pkg, tsc_ram and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Loads a task graph (node labels, edges) and on a run transaction performs two
// Kahn passes, starting in set 1 and then set 2, reporting the set switch counts.
// A label is written while idle; an edge reads the list head and tail, writes the edge
// and links it behind the old tail if the list was not empty. A clear is a clearing
// pass over in-degree and list-head memories, also run after reset, during which no
// transaction is accepted. A run scans the nodes in each pass, then serves tasks,
// walking their edges and switching sets. One transaction is in flight at a time; the
// result register holds until taken.
module two_class_topo_sort_switch_count (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [tsc_pkg::NODE_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 req_type,
  input  logic [tsc_pkg::NODE_W-1:0] node_index,
  input  logic [1:0]                 node_set,
  input  logic [tsc_pkg::NODE_W-1:0] edge_target,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [tsc_pkg::NODE_W-1:0] min_switches,
  output logic [tsc_pkg::NODE_W-1:0] switches_from_set_one,
  output logic [tsc_pkg::NODE_W-1:0] switches_from_set_two,
  output logic                       edges_dropped
);
  localparam int NW  = tsc_pkg::NODE_W;
  localparam int NAW = tsc_pkg::NODE_AW;
  localparam int EAW = tsc_pkg::EDGE_AW;
  localparam int EW  = tsc_pkg::EDGE_W;
  localparam int DW  = tsc_pkg::DEG_W;
  localparam int CW  = tsc_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_EDGE_RD, S_EDGE_WR, S_EDGE_LINK, S_SCAN, S_SERVE,
    S_TASK_WAIT, S_HEAD_WAIT, S_EDGE_WAIT, S_DEG_WAIT, S_FINISH
  } state_t;

  state_t state;
  logic [NW-1:0]  node_count;
  logic [EW-1:0]  edge_total;
  logic           drop_flag;
  logic [NAW-1:0] clr_i;
  logic [NW-1:0]  idx_r, tgt_r, d_r, scan_i, sw, sw_a;
  logic [EAW-1:0] prev_r;
  logic [EW-1:0]  link_r;
  logic [NAW-1:0] scan_si;
  logic           scan_v, pass, cur;
  logic [CW-1:0]  cnt0, cnt1;
  logic [NAW-1:0] rd0, rd1, wr0, wr1;

  logic [NW-1:0] n_eff;
  logic          accept;
  assign n_eff  = (node_count > NW'(tsc_pkg::MAX_NODES)) ? NW'(tsc_pkg::MAX_NODES) : node_count;
  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  // memory ports
  logic           ds_we, ds_wd, ds_rd;
  logic [NAW-1:0] ds_wa, ds_ra;
  logic           ld_we, wd_we, hd_we, tl_we, ed_we, el_we, q1_we, q2_we;
  logic [NAW-1:0] ld_wa, ld_ra, wd_wa, wd_ra, hd_wa, hd_ra, tl_wa, tl_ra;
  logic [DW-1:0]  ld_wd, ld_rd, wd_wd, wd_rd;
  logic [EW-1:0]  hd_wd, hd_rd, el_wd, el_rd;
  logic [EAW-1:0] tl_wd, tl_rd, ed_wa, ed_ra, el_wa, el_ra;
  logic [NW-1:0]  ed_wd, ed_rd, q1_rd, q2_rd, task_n;
  logic           push_en, push_set;
  logic [NW-1:0]  push_node;
  logic           deg_ok;

  assign task_n = cur ? q2_rd : q1_rd;
  assign deg_ok = (d_r >= NW'(1)) && (d_r <= n_eff) && (wd_rd != '0);

  always_comb begin
    ds_we = 1'b0; ds_wa = tsc_pkg::node_addr(node_index); ds_wd = node_set[1];
    ds_ra = tsc_pkg::node_addr(NW'(scan_i));
    ld_we = 1'b0; ld_wa = tsc_pkg::node_addr(tgt_r); ld_wd = ld_rd + DW'(1);
    ld_ra = tsc_pkg::node_addr(tgt_r);
    wd_we = 1'b0; wd_wa = scan_si; wd_wd = ld_rd; wd_ra = tsc_pkg::node_addr(ed_rd);
    hd_we = 1'b0; hd_wa = tsc_pkg::node_addr(idx_r); hd_wd = edge_total;
    hd_ra = tsc_pkg::node_addr(idx_r);
    tl_we = 1'b0; tl_wa = tsc_pkg::node_addr(idx_r); tl_wd = edge_total[EAW-1:0];
    tl_ra = tsc_pkg::node_addr(idx_r);
    ed_we = 1'b0; ed_wa = edge_total[EAW-1:0]; ed_wd = tgt_r; ed_ra = link_r[EAW-1:0];
    el_we = 1'b0; el_wa = edge_total[EAW-1:0]; el_wd = tsc_pkg::EDGE_END;
    el_ra = link_r[EAW-1:0];
    push_en = 1'b0; push_set = ds_rd; push_node = NW'(scan_si) + NW'(1);
    case (state)
      S_IDLE: begin
        ds_we = accept && (req_type == tsc_pkg::REQ_LABEL) && (node_index >= NW'(1))
                && (node_index <= NW'(tsc_pkg::MAX_NODES))
                && ((node_set == 2'd1) || (node_set == 2'd2));
      end
      S_CLR: begin
        ld_we = 1'b1; ld_wa = clr_i; ld_wd = '0;
        hd_we = 1'b1; hd_wa = clr_i; hd_wd = tsc_pkg::EDGE_END;
      end
      S_EDGE_WR: begin
        ed_we = 1'b1; el_we = 1'b1; ld_we = 1'b1; tl_we = 1'b1;
        hd_we = (hd_rd >= tsc_pkg::EDGE_END);
      end
      S_EDGE_LINK: begin
        el_we = 1'b1; el_wa = prev_r; el_wd = edge_total;
      end
      S_SCAN: begin
        ld_ra = scan_i[NAW-1:0];
        ds_ra = scan_i[NAW-1:0];
        if (scan_v) begin
          wd_we = 1'b1;
          push_en = (ld_rd == '0);
        end
      end
      S_TASK_WAIT: hd_ra = tsc_pkg::node_addr(task_n);
      S_HEAD_WAIT: begin
        ed_ra = hd_rd[EAW-1:0];
        el_ra = hd_rd[EAW-1:0];
      end
      S_EDGE_WAIT: ds_ra = tsc_pkg::node_addr(ed_rd);
      S_DEG_WAIT: begin
        wd_wa = tsc_pkg::node_addr(d_r); wd_wd = wd_rd - DW'(1);
        wd_we = deg_ok;
        push_en = deg_ok && (wd_rd == DW'(1));
        push_node = d_r;
      end
      default: begin
      end
    endcase
    // a full queue refuses the push, as a node enters at most once
    if (push_set ? (cnt1 >= CW'(tsc_pkg::MAX_NODES)) : (cnt0 >= CW'(tsc_pkg::MAX_NODES))) begin
      push_en = 1'b0;
    end
    q1_we = push_en && !push_set;
    q2_we = push_en && push_set;
  end

  tsc_ram #(.WIDTH(1), .DEPTH(tsc_pkg::MAX_NODES)) u_ds (
    .clk, .we(ds_we), .waddr(ds_wa), .wdata(ds_wd), .raddr(ds_ra), .rdata(ds_rd));
  tsc_ram #(.WIDTH(DW), .DEPTH(tsc_pkg::MAX_NODES)) u_ldeg (
    .clk, .we(ld_we), .waddr(ld_wa), .wdata(ld_wd), .raddr(ld_ra), .rdata(ld_rd));
  tsc_ram #(.WIDTH(DW), .DEPTH(tsc_pkg::MAX_NODES)) u_wdeg (
    .clk, .we(wd_we), .waddr(wd_wa), .wdata(wd_wd), .raddr(wd_ra), .rdata(wd_rd));
  tsc_ram #(.WIDTH(EW), .DEPTH(tsc_pkg::MAX_NODES)) u_head (
    .clk, .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
  tsc_ram #(.WIDTH(EAW), .DEPTH(tsc_pkg::MAX_NODES)) u_tail (
    .clk, .we(tl_we), .waddr(tl_wa), .wdata(tl_wd), .raddr(tl_ra), .rdata(tl_rd));
  tsc_ram #(.WIDTH(NW), .DEPTH(tsc_pkg::MAX_EDGES)) u_edst (
    .clk, .we(ed_we), .waddr(ed_wa), .wdata(ed_wd), .raddr(ed_ra), .rdata(ed_rd));
  tsc_ram #(.WIDTH(EW), .DEPTH(tsc_pkg::MAX_EDGES)) u_elink (
    .clk, .we(el_we), .waddr(el_wa), .wdata(el_wd), .raddr(el_ra), .rdata(el_rd));
  tsc_ram #(.WIDTH(NW), .DEPTH(tsc_pkg::MAX_NODES)) u_q1 (
    .clk, .we(q1_we), .waddr(wr0), .wdata(push_node), .raddr(rd0), .rdata(q1_rd));
  tsc_ram #(.WIDTH(NW), .DEPTH(tsc_pkg::MAX_NODES)) u_q2 (
    .clk, .we(q2_we), .waddr(wr1), .wdata(push_node), .raddr(rd1), .rdata(q2_rd));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      node_count <= NW'(1);
      edge_total <= '0;
      drop_flag  <= 1'b0;
      clr_i      <= '0;
      out_valid  <= 1'b0;
      scan_v     <= 1'b0;
      pass       <= 1'b0;
      cur        <= 1'b0;
      cnt0 <= '0; cnt1 <= '0; rd0 <= '0; rd1 <= '0; wr0 <= '0; wr1 <= '0;
    end else begin
      if (cfg_wr_en) begin
        node_count <= cfg_wr_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (push_en) begin
        if (push_set) begin
          wr1 <= wr1 + NAW'(1); cnt1 <= cnt1 + CW'(1);
        end else begin
          wr0 <= wr0 + NAW'(1); cnt0 <= cnt0 + CW'(1);
        end
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            idx_r <= node_index;
            tgt_r <= edge_target;
            case (req_type)
              tsc_pkg::REQ_EDGE: begin
                if ((node_index < NW'(1)) || (node_index > n_eff) ||
                    (edge_target < NW'(1)) || (edge_target > n_eff) ||
                    (edge_total >= EW'(tsc_pkg::MAX_EDGES))) begin
                  drop_flag <= 1'b1;
                end else begin
                  state <= S_EDGE_RD;
                end
              end
              tsc_pkg::REQ_RUN: begin
                pass <= 1'b0; cur <= 1'b0; sw <= '0;
                scan_i <= '0; scan_v <= 1'b0;
                cnt0 <= '0; cnt1 <= '0; rd0 <= '0; rd1 <= '0; wr0 <= '0; wr1 <= '0;
                state <= S_SCAN;
              end
              tsc_pkg::REQ_CLEAR: begin
                edge_total <= '0;
                drop_flag  <= 1'b0;
                clr_i      <= '0;
                state      <= S_CLR;
              end
              default: begin
              end
            endcase
          end
        end
        S_CLR: begin
          clr_i <= clr_i + NAW'(1);
          if (clr_i == NAW'(tsc_pkg::MAX_NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_EDGE_RD: state <= S_EDGE_WR;
        S_EDGE_WR: begin
          if (hd_rd >= tsc_pkg::EDGE_END) begin
            edge_total <= edge_total + EW'(1);
            state <= S_IDLE;
          end else begin
            prev_r <= tl_rd;
            state  <= S_EDGE_LINK;
          end
        end
        S_EDGE_LINK: begin
          edge_total <= edge_total + EW'(1);
          state <= S_IDLE;
        end
        S_SCAN: begin
          scan_si <= scan_i[NAW-1:0];
          if (scan_i < n_eff) begin
            scan_i <= scan_i + NW'(1);
            scan_v <= 1'b1;
          end else begin
            scan_v <= 1'b0;
            if (!scan_v) begin
              state <= S_SERVE;
            end
          end
        end
        S_SERVE: begin
          if ((cnt0 == '0) && (cnt1 == '0)) begin
            if (!pass) begin
              sw_a <= sw;
              pass <= 1'b1; cur <= 1'b1; sw <= '0;
              scan_i <= '0; scan_v <= 1'b0;
              rd0 <= '0; rd1 <= '0; wr0 <= '0; wr1 <= '0;
              state <= S_SCAN;
            end else begin
              state <= S_FINISH;
            end
          end else if (cur ? (cnt1 == '0) : (cnt0 == '0)) begin
            sw  <= sw + NW'(1);
            cur <= !cur;
          end else begin
            if (cur) begin
              rd1 <= rd1 + NAW'(1); cnt1 <= cnt1 - CW'(1);
            end else begin
              rd0 <= rd0 + NAW'(1); cnt0 <= cnt0 - CW'(1);
            end
            state <= S_TASK_WAIT;
          end
        end
        S_TASK_WAIT: state <= S_HEAD_WAIT;
        S_HEAD_WAIT: begin
          state <= (hd_rd >= tsc_pkg::EDGE_END) ? S_SERVE : S_EDGE_WAIT;
        end
        S_EDGE_WAIT: begin
          d_r    <= ed_rd;
          link_r <= el_rd;
          state  <= S_DEG_WAIT;
        end
        S_DEG_WAIT: begin
          state <= (link_r >= tsc_pkg::EDGE_END) ? S_SERVE : S_EDGE_WAIT;
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid             <= 1'b1;
            switches_from_set_one <= sw_a;
            switches_from_set_two <= sw;
            min_switches          <= (sw_a < sw) ? sw_a : sw;
            edges_dropped         <= drop_flag;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the edge in flight during the walk was loaded from memory the cycle before
  `ASSERT_ALWAYS(a_queue_bound, (cnt0 <= CW'(tsc_pkg::MAX_NODES)) && (cnt1 <= CW'(tsc_pkg::MAX_NODES)))
  `ASSERT_ALWAYS(a_edge_bound, edge_total <= EW'(tsc_pkg::MAX_EDGES))
  `ASSERT_IMPLY(a_push_state, push_en, (state == S_SCAN) || (state == S_DEG_WAIT))
  `ASSERT_IMPLY(a_min_ok, out_valid, (min_switches <= switches_from_set_one) && (min_switches <= switches_from_set_two))
  `ASSERT_NEXT(a_finish_out, (state == S_FINISH) && !out_valid, out_valid && (state == S_IDLE))
endmodule

// File: tb/sv/two_class_topo_sort_switch_count_test.sv
// self-checking testbench for two_class_topo_sort_switch_count
// depends on tsc_pkg and the rtl of the block; holds its own switch-count predictor
`timescale 1ns / 1ps
module two_class_topo_sort_switch_count_test;
  import tsc_pkg::*;

  localparam int DRAIN_CYCLES = 1200;
  localparam int CYCLE_LIMIT  = 1500000;
  // nodes that get a set up front; runs never look past them
  localparam int LABELED      = 64;

  typedef struct {
    bit               is_cfg;
    logic [NODE_W-1:0] cfg_val;
    req_t             req;
    logic [NODE_W-1:0] idx;
    logic [1:0]       set;
    logic [NODE_W-1:0] tgt;
  } txn_t;

  typedef struct {
    logic [NODE_W-1:0] min_sw;
    logic [NODE_W-1:0] sw_one;
    logic [NODE_W-1:0] sw_two;
    logic              dropped;
  } counts_t;

  logic clk, rst;
  logic cfg_wr_en;
  logic [NODE_W-1:0] cfg_wr_data;
  logic in_valid, in_stall;
  logic [1:0] req_type;
  logic [NODE_W-1:0] node_index;
  logic [1:0] node_set;
  logic [NODE_W-1:0] edge_target;
  logic out_valid, out_stall;
  logic [NODE_W-1:0] min_switches, switches_from_set_one, switches_from_set_two;
  logic edges_dropped;

  two_class_topo_sort_switch_count dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .node_index(node_index), .node_set(node_set),
    .edge_target(edge_target),
    .out_valid(out_valid), .out_stall(out_stall),
    .min_switches(min_switches), .switches_from_set_one(switches_from_set_one),
    .switches_from_set_two(switches_from_set_two), .edges_dropped(edges_dropped)
  );

  // graph mirror
  int unsigned node_total;
  bit          in_set_two [1:MAX_NODES];
  int unsigned indeg      [0:MAX_NODES];
  int unsigned adj_first  [0:MAX_NODES];
  int unsigned adj_last   [0:MAX_NODES];
  int unsigned edge_dst   [0:MAX_EDGES-1];
  int unsigned edge_next  [0:MAX_EDGES-1];
  int unsigned edge_cnt;
  bit          drop_seen;

  txn_t    pending_q [$];
  counts_t counts_q [$];
  int      err_cnt;
  bit      quiet;

  function automatic int unsigned live_nodes();
    return node_total > MAX_NODES ? MAX_NODES : node_total;
  endfunction

  function automatic void wipe_graph();
    for (int i = 0; i <= MAX_NODES; i++) begin
      indeg[i] = 0;
      adj_first[i] = MAX_EDGES;
      adj_last[i] = 0;
    end
    edge_cnt = 0;
    drop_seen = 0;
  endfunction

  function automatic int unsigned count_switches(bit start_two);
    int unsigned n, sw, task_id, e, d;
    int unsigned wdeg [0:MAX_NODES];
    int unsigned ready [2][$];
    bit cur;
    n = live_nodes();
    sw = 0;
    cur = start_two;
    wdeg = indeg;
    for (int i = 1; i <= n; i++)
      if (wdeg[i] == 0) ready[in_set_two[i]].insert(ready[in_set_two[i]].size(), i);
    while (ready[0].size() != 0 || ready[1].size() != 0) begin
      if (ready[cur].size() == 0) begin
        sw++;
        cur = !cur;
      end else begin
        task_id = ready[cur].pop_front();
        e = adj_first[task_id];
        while (e < MAX_EDGES && e < edge_cnt) begin
          d = edge_dst[e];
          if (d >= 1 && d <= n && wdeg[d] != 0) begin
            wdeg[d]--;
            if (wdeg[d] == 0 && ready[in_set_two[d]].size() < MAX_NODES)
              ready[in_set_two[d]].insert(ready[in_set_two[d]].size(), d);
          end
          e = edge_next[e];
        end
      end
    end
    return sw & 'h7FF;
  endfunction

  function automatic void apply_txn(txn_t t);
    int unsigned n, a, b;
    counts_t c;
    n = live_nodes();
    case (t.req)
      REQ_LABEL: begin
        if (t.idx >= 1 && t.idx <= MAX_NODES && (t.set == 1 || t.set == 2))
          in_set_two[t.idx] = (t.set == 2);
      end
      REQ_EDGE: begin
        if (t.idx < 1 || t.idx > n || t.tgt < 1 || t.tgt > n || edge_cnt >= MAX_EDGES) begin
          drop_seen = 1;
        end else begin
          edge_dst[edge_cnt] = t.tgt;
          edge_next[edge_cnt] = MAX_EDGES;
          if (adj_first[t.idx] >= MAX_EDGES) adj_first[t.idx] = edge_cnt;
          else edge_next[adj_last[t.idx]] = edge_cnt;
          adj_last[t.idx] = edge_cnt;
          edge_cnt++;
          indeg[t.tgt]++;
        end
      end
      REQ_RUN: begin
        a = count_switches(0);
        b = count_switches(1);
        c.min_sw = NODE_W'((a < b) ? a : b);
        c.sw_one = NODE_W'(a);
        c.sw_two = NODE_W'(b);
        c.dropped = drop_seen;
        counts_q.insert(counts_q.size(), c);
      end
      default: wipe_graph();
    endcase
  endfunction

  task automatic report(string what, logic [NODE_W-1:0] got, logic [NODE_W-1:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  function automatic void add_item(req_t r, int idx, int set, int tgt);
    txn_t t;
    t.is_cfg = 0;
    t.cfg_val = '0;
    t.req = r;
    t.idx = NODE_W'(idx);
    t.set = 2'(set);
    t.tgt = NODE_W'(tgt);
    pending_q.insert(pending_q.size(), t);
  endfunction

  function automatic void add_cfg(int v);
    txn_t t;
    t.is_cfg = 1;
    t.cfg_val = NODE_W'(v);
    t.req = REQ_LABEL;
    t.idx = '0;
    t.set = '0;
    t.tgt = '0;
    pending_q.insert(pending_q.size(), t);
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  int unsigned cycle_cnt;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // input side: prediction on every accepted transaction
  bit in_taken;
  always @(posedge clk) begin
    in_taken <= 0;
    if (!rst && in_valid && !in_stall) begin
      txn_t t;
      t.is_cfg = 0;
      t.cfg_val = '0;
      t.req = req_t'(req_type);
      t.idx = node_index;
      t.set = node_set;
      t.tgt = edge_target;
      apply_txn(t);
      in_taken <= 1;
    end
  end

  // driver
  int gap_left, drain_wait;
  always @(negedge clk) begin
    bit v, we;
    logic [NODE_W-1:0] wd;
    txn_t t;
    v = in_valid;
    we = 0;
    wd = cfg_wr_data;
    if (rst) begin
      v = 0;
    end else if (!in_valid || in_taken) begin
      v = 0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() != 0) begin
        if (pending_q[0].is_cfg) begin
          // block must be idle, including a clear that produces no result
          if (counts_q.size() != 0 || in_valid) drain_wait = 0;
          else if (drain_wait < DRAIN_CYCLES) drain_wait++;
          else begin
            t = pending_q.pop_front();
            we = 1;
            wd = t.cfg_val;
            node_total = t.cfg_val;
            drain_wait = 0;
          end
        end else begin
          t = pending_q.pop_front();
          v = 1;
          req_type <= t.req;
          node_index <= t.idx;
          node_set <= t.set;
          edge_target <= t.tgt;
          if (!quiet && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 5);
        end
      end
    end
    in_valid <= v;
    cfg_wr_en <= we;
    cfg_wr_data <= wd;
  end

  // receiver stall bursts
  int stall_left;
  always @(negedge clk) begin
    bit s;
    s = 0;
    if (stall_left > 0) begin
      stall_left--;
      s = 1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 4);
      s = 1;
    end
    out_stall <= s;
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      counts_t c;
      if (counts_q.size() == 0) begin
        $display("unexpected result transaction at %0t", $realtime);
        err_cnt++;
      end else begin
        c = counts_q.pop_front();
        if (min_switches !== c.min_sw) report("min_switches", min_switches, c.min_sw);
        if (switches_from_set_one !== c.sw_one)
          report("switches_from_set_one", switches_from_set_one, c.sw_one);
        if (switches_from_set_two !== c.sw_two)
          report("switches_from_set_two", switches_from_set_two, c.sw_two);
        if (edges_dropped !== c.dropped)
          report("edges_dropped", NODE_W'(edges_dropped), NODE_W'(c.dropped));
      end
    end
  end

  initial begin
    int n, k, r, src, random_items;
    rst = 1;
    cfg_wr_en = 0;
    cfg_wr_data = '0;
    in_valid = 0;
    out_stall = 0;
    req_type = REQ_LABEL;
    node_index = '0;
    node_set = '0;
    edge_target = '0;
    err_cnt = 0;
    quiet = 0;
    cycle_cnt = 0;
    gap_left = 0;
    drain_wait = 0;
    stall_left = 0;
    node_total = 1;
    wipe_graph();
    for (int i = 1; i <= MAX_NODES; i++) in_set_two[i] = 0;

    // every node a run can reach gets a set first
    for (int i = 1; i <= LABELED; i++) add_item(REQ_LABEL, i, $urandom_range(1, 2), 0);

    // directed: single node, empty count, oversized count, then a small graph
    add_item(REQ_RUN, 0, 0, 0);
    add_cfg(0);
    add_item(REQ_EDGE, 1, 0, 1);
    add_item(REQ_RUN, 0, 0, 0);
    add_cfg(2047);
    add_item(REQ_EDGE, 1024, 0, 1);
    add_item(REQ_EDGE, 2047, 0, 5);
    add_item(REQ_EDGE, 64, 0, 2);
    // node 1024 is absent now but still holds node 1 back
    add_cfg(LABELED);
    add_item(REQ_RUN, 0, 0, 0);
    add_cfg(5);
    add_item(REQ_CLEAR, 0, 0, 0);
    add_item(REQ_LABEL, 1, 1, 0);
    add_item(REQ_LABEL, 2, 2, 0);
    add_item(REQ_LABEL, 0, 2, 0);
    add_item(REQ_LABEL, 2047, 1, 0);
    add_item(REQ_LABEL, 3, 0, 0);
    add_item(REQ_LABEL, 3, 3, 0);
    add_item(REQ_EDGE, 1, 0, 2);
    add_item(REQ_EDGE, 2, 0, 3);
    add_item(REQ_EDGE, 4, 0, 5);
    add_item(REQ_EDGE, 5, 0, 4);
    add_item(REQ_EDGE, 0, 0, 1);
    add_item(REQ_EDGE, 1, 0, 6);
    add_item(REQ_RUN, 0, 0, 0);
    add_item(REQ_CLEAR, 0, 0, 0);
    add_item(REQ_RUN, 0, 0, 0);
    // lower the count under loaded edges
    add_item(REQ_EDGE, 1, 0, 5);
    add_item(REQ_EDGE, 5, 0, 2);
    add_cfg(3);
    add_item(REQ_RUN, 0, 0, 0);

    // random phases, mostly small acyclic graphs
    random_items = 0;
    while (random_items < 400) begin
      r = $urandom_range(0, 99);
      if (r < 8) n = $urandom_range(0, 1);
      else if (r < 20) n = $urandom_range(13, LABELED);
      else n = $urandom_range(2, 12);
      add_cfg(n);
      if ($urandom_range(0, 9) < 7) add_item(REQ_CLEAR, 0, 0, 0);
      k = $urandom_range(2, 20);
      for (int j = 0; j < k; j++) begin
        r = $urandom_range(0, 99);
        if (r < 50 && n >= 2) begin
          src = $urandom_range(1, n - 1);
          add_item(REQ_EDGE, src, 0, $urandom_range(src + 1, n));
        end else if (r < 60 && n >= 1) begin
          add_item(REQ_EDGE, $urandom_range(1, n), $urandom_range(0, 3), $urandom_range(1, n));
        end else if (r < 70) begin
          add_item(REQ_EDGE, $urandom_range(0, 2047), $urandom_range(0, 3),
                   $urandom_range(0, 2047));
        end else if (r < 85) begin
          add_item(REQ_LABEL, $urandom_range(1, n < 1 ? 1 : n), $urandom_range(1, 2), 0);
        end else if (r < 90) begin
          add_item(REQ_LABEL, $urandom_range(0, 2047), $urandom_range(0, 3),
                   $urandom_range(0, 2047));
        end else if (r < 92) begin
          add_item(REQ_CLEAR, $urandom_range(0, 2047), 0, 0);
        end else begin
          add_item(REQ_RUN, $urandom_range(0, 2047), $urandom_range(0, 3),
                   $urandom_range(0, 2047));
        end
      end
      add_item(REQ_RUN, 0, 0, 0);
      random_items += k + 1;
    end

    repeat (11) @(posedge clk);
    @(negedge clk) rst = 0;

    // calm tail: no idling once little stimulus is left
    wait (pending_q.size() < 60);
    quiet = 1;
    wait (pending_q.size() == 0 && !in_valid && !cfg_wr_en && counts_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && counts_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/tsc_pkg.sv
rtl/core/tsc_ram.sv
rtl/core/two_class_topo_sort_switch_count.sv
tb/sv/two_class_topo_sort_switch_count_test.sv
